// ===== hw/rtl/hrc_pkg.sv =====
`default_nettype none

package hrc_pkg;

    // Table geometry and field widths
    localparam int SLOTS      = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int REF_BITS   = 16;
    localparam int CHECK_W    = 31;
    localparam int WORD_W     = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int REF_OUT_W  = 16;
    localparam int MEM_W      = CHECK_W + REF_BITS;

    // A check word of all ones matches any stored check
    localparam logic [WORD_W-1:0] WILDCARD = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CREATE     = 3'd0;
    localparam logic [OP_W-1:0] OP_GET        = 3'd1;
    localparam logic [OP_W-1:0] OP_PUT        = 3'd2;
    localparam logic [OP_W-1:0] OP_DESTROY    = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;
    localparam logic [OP_W-1:0] OP_ITER_RESET = 3'd5;
    localparam logic [OP_W-1:0] OP_ITER_NEXT  = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ITER_END = 2'd3;

    // Slot states
    localparam logic [1:0] SS_EMPTY   = 2'd0;
    localparam logic [1:0] SS_PENDING = 2'd1;
    localparam logic [1:0] SS_ACTIVE  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [WORD_W-1:0]  handle_index;
        logic [WORD_W-1:0]  handle_check;
        logic [CHECK_W-1:0] new_check;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot_out;
        logic [CHECK_W-1:0]    check_out;
        logic [REF_OUT_W-1:0]  ref_count_out;
    } out_item_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } pick_t;

    // Update request from the execute step to the occupancy map
    typedef struct packed {
        logic              state_we;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        state;
        logic              grow;
        logic              iter_we;
        logic [CNT_W-1:0]  iter_val;
    } map_upd_t;

    // Search results and counters seen by the control logic
    typedef struct packed {
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic              iter_found;
        logic [SLOT_W-1:0] iter_slot;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  iter_pos;
        logic              look_active;
    } map_view_t;

    // Priority encoder: lowest set bit of the vector
    function automatic pick_t first_set(input logic [SLOTS-1:0] v);
        pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p.found = 1'b1;
                p.idx   = SLOT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/handle_table_refcount.sv =====
// A result is registered by the execute step that follows its input transfer; the
// block takes no new item until that execute step has completed.
// Each item is handled as a read-modify-write of the slot memory: a read on
// transfer, then an update and write back in the execute step. A result
// still waiting in the output register holds the execute step until it leaves.
// Free-slot and iterator searches come combinationally from a flop occupancy map.
// Reset: asynchronous, active low; all slots empty, used count and iterator
// position zero. The slot memory needs no clearing pass.
`default_nettype none

module handle_table_refcount (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hrc_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hrc_pkg::out_item_t     out_item
);
    import hrc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // Context of the item under way, captured on transfer
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               idx_ok;
        logic [WORD_W-1:0]  chk;
        logic [CHECK_W-1:0] nchk;
        logic [SLOT_W-1:0]  slot;
        logic               grow;
        logic               full;
        logic               at_end;
        logic               found;
    } ctx_t;

    state_t            state_reg, state_next;
    ctx_t              ctx_reg, ctx_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, res;
    logic              accept;
    logic              out_free;
    logic              exec_fire;
    map_view_t         view;
    map_upd_t          upd, upd_gated;
    logic              mem_we;
    logic [MEM_W-1:0]  mem_wdata;
    logic [MEM_W-1:0]  mem_rdata;
    logic [CHECK_W-1:0] stored_chk;
    logic [REF_BITS-1:0] stored_refs;
    logic [REF_BITS-1:0] inc_refs;
    logic [REF_BITS-1:0] dec_refs;
    logic              handle_good;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;

    // Decode on transfer: pick the slot to read and note early errors
    always_comb
    begin
        ctx_next        = '0;
        ctx_next.op     = in_item.op;
        ctx_next.chk    = in_item.handle_check;
        ctx_next.nchk   = in_item.new_check;
        ctx_next.idx_ok = in_item.handle_index < WORD_W'(view.used_count);
        ctx_next.slot   = in_item.handle_index[SLOT_W-1:0];
        case (in_item.op)
            OP_CREATE:
            begin
                if (view.free_found)
                begin
                    ctx_next.slot = view.free_slot;
                end
                else
                begin
                    ctx_next.slot = view.used_count[SLOT_W-1:0];
                    if (view.used_count == CNT_W'(SLOTS))
                    begin
                        ctx_next.full = 1'b1;
                    end
                    else
                    begin
                        ctx_next.grow = 1'b1;
                    end
                end
            end
            OP_ITER_NEXT:
            begin
                ctx_next.at_end = (view.iter_pos >= view.used_count);
                ctx_next.found  = view.iter_found;
                ctx_next.slot   = view.iter_slot;
            end
            default:
            begin
                ctx_next.slot = in_item.handle_index[SLOT_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // Check values and reference counts
    hrc_slot_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (exec_fire && mem_we),
        .waddr (ctx_reg.slot),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (ctx_next.slot),
        .rdata (mem_rdata)
    );

    // Slot states, high-water mark and iterator position
    hrc_slot_map u_slot_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd_gated),
        .look_slot (ctx_reg.slot),
        .view      (view)
    );

    assign stored_chk  = mem_rdata[MEM_W-1:REF_BITS];
    assign stored_refs = mem_rdata[REF_BITS-1:0];
    assign inc_refs    = stored_refs + REF_BITS'(1);
    assign dec_refs    = stored_refs - REF_BITS'(1);
    assign handle_good = ctx_reg.idx_ok
                         && ((ctx_reg.chk == WILDCARD)
                             || (ctx_reg.chk == {1'b0, stored_chk}));

    // Execute: modify the slot, build the result and the map update
    always_comb
    begin
        res       = '0;
        upd       = '0;
        upd.slot  = ctx_reg.slot;
        mem_we    = 1'b0;
        mem_wdata = {stored_chk, stored_refs};
        case (ctx_reg.op)
            OP_CREATE:
            begin
                if (ctx_reg.full)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    mem_we            = 1'b1;
                    mem_wdata         = {ctx_reg.nchk, REF_BITS'(1)};
                    upd.state_we      = 1'b1;
                    upd.state         = SS_ACTIVE;
                    upd.grow          = ctx_reg.grow;
                    res.slot_out      = SLOT_OUT_W'(ctx_reg.slot);
                    res.check_out     = ctx_reg.nchk;
                    res.ref_count_out = REF_OUT_W'(REF_BITS'(1));
                end
            end
            OP_GET:
            begin
                if (handle_good && view.look_active)
                begin
                    mem_we            = 1'b1;
                    mem_wdata         = {stored_chk, inc_refs};
                    res.ref_count_out = REF_OUT_W'(inc_refs);
                end
                else
                begin
                    res.status = STAT_BAD;
                end
            end
            OP_PUT, OP_DESTROY:
            begin
                if (handle_good)
                begin
                    mem_we            = 1'b1;
                    res.ref_count_out = REF_OUT_W'(dec_refs);
                    if (dec_refs == '0)
                    begin
                        mem_wdata    = '0;
                        upd.state_we = 1'b1;
                        upd.state    = SS_EMPTY;
                    end
                    else
                    begin
                        mem_wdata    = {stored_chk, dec_refs};
                        upd.state_we = (ctx_reg.op == OP_DESTROY);
                        upd.state    = SS_PENDING;
                    end
                end
                else
                begin
                    res.status = STAT_BAD;
                end
            end
            OP_QUERY:
            begin
                if (handle_good)
                begin
                    res.ref_count_out = REF_OUT_W'(stored_refs);
                end
                else
                begin
                    res.status = STAT_BAD;
                end
            end
            OP_ITER_RESET:
            begin
                upd.iter_we  = 1'b1;
                upd.iter_val = '0;
            end
            OP_ITER_NEXT:
            begin
                if (ctx_reg.at_end)
                begin
                    res.status = STAT_ITER_END;
                end
                else if (ctx_reg.found)
                begin
                    mem_we            = 1'b1;
                    mem_wdata         = {stored_chk, inc_refs};
                    upd.iter_we       = 1'b1;
                    upd.iter_val      = CNT_W'(ctx_reg.slot) + CNT_W'(1);
                    res.slot_out      = SLOT_OUT_W'(ctx_reg.slot);
                    res.check_out     = stored_chk;
                    res.ref_count_out = REF_OUT_W'(inc_refs);
                end
                else
                begin
                    upd.iter_we  = 1'b1;
                    upd.iter_val = view.used_count;
                    res.status   = STAT_BAD;
                end
            end
            default:
            begin
                res.status = STAT_BAD;
            end
        endcase
    end

    // Only commit the update on the cycle the result is registered
    always_comb
    begin
        upd_gated          = upd;
        upd_gated.state_we = upd.state_we && exec_fire;
        upd_gated.grow     = upd.grow && exec_fire;
        upd_gated.iter_we  = upd.iter_we && exec_fire;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register parts the result from the next transfer in
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A transfer in always starts the execute step on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("transfer in not followed by execute step");

    // Every completed execute step leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid)
        else $error("execute step produced no result");

    // A create that is not refused always marks its slot active
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && (ctx_reg.op == OP_CREATE) && !ctx_reg.full)
        |-> (upd_gated.state_we && (upd_gated.state == SS_ACTIVE) && mem_we))
        else $error("create did not claim its slot");

endmodule

`default_nettype wire

// ===== hw/rtl/hrc_slot_ram.sv =====
`default_nettype none

module hrc_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hrc_slot_map.sv =====
`default_nettype none

module hrc_slot_map (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hrc_pkg::map_upd_t            upd,
    input  wire logic [hrc_pkg::SLOT_W-1:0]   look_slot,
    output hrc_pkg::map_view_t                view
);
    import hrc_pkg::*;

    logic [SLOTS-1:0] active_reg, active_next;
    logic [SLOTS-1:0] pending_reg, pending_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;
    logic [CNT_W-1:0] iter_pos_reg, iter_pos_next;
    logic [SLOTS-1:0] free_vec;
    logic [SLOTS-1:0] iter_vec;
    pick_t            free_pick;
    pick_t            iter_pick;

    // Apply the update requested by the execute step
    always_comb
    begin
        active_next     = active_reg;
        pending_next    = pending_reg;
        used_count_next = used_count_reg;
        iter_pos_next   = iter_pos_reg;
        if (upd.state_we)
        begin
            active_next[upd.slot]  = (upd.state == SS_ACTIVE);
            pending_next[upd.slot] = (upd.state == SS_PENDING);
        end
        if (upd.grow)
        begin
            used_count_next = used_count_reg + CNT_W'(1);
        end
        if (upd.iter_we)
        begin
            iter_pos_next = upd.iter_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            pending_reg    <= '0;
            used_count_reg <= '0;
            iter_pos_reg   <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            pending_reg    <= pending_next;
            used_count_reg <= used_count_next;
            iter_pos_reg   <= iter_pos_next;
        end
    end

    // Candidate slots for create and for the iterator
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            free_vec[i] = !active_reg[i] && !pending_reg[i]
                          && (CNT_W'(i) < used_count_reg);
            iter_vec[i] = active_reg[i] && (CNT_W'(i) < used_count_reg)
                          && (CNT_W'(i) >= iter_pos_reg);
        end
    end

    assign free_pick = first_set(free_vec);
    assign iter_pick = first_set(iter_vec);

    always_comb
    begin
        view.free_found  = free_pick.found;
        view.free_slot   = free_pick.idx;
        view.iter_found  = iter_pick.found;
        view.iter_slot   = iter_pick.idx;
        view.used_count  = used_count_reg;
        view.iter_pos    = iter_pos_reg;
        view.look_active = active_reg[look_slot];
    end

    // The high-water mark stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_W'(SLOTS))
        else $error("used count beyond table size");

    // The iterator never runs past the high-water mark
    assert property (@(posedge clk) disable iff (!rst_n)
        iter_pos_reg <= used_count_reg)
        else $error("iterator position beyond used count");

    // A slot is never both active and pending removal
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & pending_reg) == '0)
        else $error("slot marked active and pending at once");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import hrc_pkg::*;

    // Opcode that the block does not define
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Mixes of operations used by the random test
    localparam int MIX_SHRINK   = 0;
    localparam int MIX_BALANCED = 1;
    localparam int MIX_GROW     = 2;
    localparam int MIX_STEADY   = 3;

    localparam int RANDOM_ITEMS = 520;
    localparam int GET_BURST    = 30;
    localparam int DRAIN_CYCLES = 1000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Shadow copy of the handle table
    logic [1:0]          tbl_state [SLOTS];
    logic [CHECK_W-1:0]  tbl_check [SLOTS];
    logic [REF_BITS-1:0] tbl_refs [SLOTS];
    logic [CNT_W-1:0]    tbl_used;
    logic [CNT_W-1:0]    tbl_iter;

    out_item_t expected_results [$];
    out_item_t last_expected;

    bit idle_on = 1'b1;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    handle_table_refcount dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Clears the shadow table to its reset contents.
    function automatic void table_clear();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_state[i] = SS_EMPTY;
            tbl_check[i] = '0;
            tbl_refs[i]  = '0;
        end
        tbl_used = '0;
        tbl_iter = '0;
    endfunction

    // Applies one operation to the shadow table and returns the result it should give.
    function automatic out_item_t table_apply(input in_item_t it);
        out_item_t          res;
        logic [SLOT_W-1:0]  s;
        logic               good;
        logic               found;
        int                 slot;
        int                 p;
        res  = '0;
        s    = it.handle_index[SLOT_W-1:0];
        good = (it.handle_index < tbl_used) &&
               (it.handle_check == WILDCARD || it.handle_check == {1'b0, tbl_check[s]});
        case (it.op)
            OP_CREATE:
            begin
                slot = -1;
                for (int i = 0; i < tbl_used; i++)
                begin
                    if (slot < 0 && tbl_state[i] == SS_EMPTY)
                        slot = i;
                end
                if (slot < 0 && tbl_used < SLOTS)
                begin
                    slot     = int'(tbl_used);
                    tbl_used = tbl_used + 1'b1;
                end
                if (slot < 0)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    tbl_state[slot]   = SS_ACTIVE;
                    tbl_check[slot]   = it.new_check;
                    tbl_refs[slot]    = REF_BITS'(1);
                    res.status        = STAT_OK;
                    res.slot_out      = SLOT_OUT_W'(slot);
                    res.check_out     = it.new_check;
                    res.ref_count_out = REF_OUT_W'(tbl_refs[slot]);
                end
            end
            OP_GET:
            begin
                if (good && tbl_state[s] == SS_ACTIVE)
                begin
                    tbl_refs[s]       = tbl_refs[s] + 1'b1;
                    res.ref_count_out = REF_OUT_W'(tbl_refs[s]);
                end
                else
                begin
                    res.status = STAT_BAD;
                end
            end
            OP_PUT, OP_DESTROY:
            begin
                if (good)
                begin
                    if (it.op == OP_DESTROY)
                        tbl_state[s] = SS_PENDING;
                    tbl_refs[s] = tbl_refs[s] - 1'b1;
                    if (tbl_refs[s] == 0)
                    begin
                        tbl_state[s] = SS_EMPTY;
                        tbl_check[s] = '0;
                    end
                    res.ref_count_out = REF_OUT_W'(tbl_refs[s]);
                end
                else
                begin
                    res.status = STAT_BAD;
                end
            end
            OP_QUERY:
            begin
                if (good)
                    res.ref_count_out = REF_OUT_W'(tbl_refs[s]);
                else
                    res.status = STAT_BAD;
            end
            OP_ITER_RESET:
            begin
                tbl_iter = '0;
            end
            OP_ITER_NEXT:
            begin
                // The scan stops at the first active slot and takes a reference on it.
                res.status = STAT_ITER_END;
                found      = 1'b0;
                while (!found && tbl_iter < tbl_used)
                begin
                    p          = int'(tbl_iter);
                    tbl_iter   = tbl_iter + 1'b1;
                    res.status = STAT_BAD;
                    if (tbl_state[p] == SS_ACTIVE)
                    begin
                        found             = 1'b1;
                        tbl_refs[p]       = tbl_refs[p] + 1'b1;
                        res.status        = STAT_OK;
                        res.slot_out      = SLOT_OUT_W'(p);
                        res.check_out     = tbl_check[p];
                        res.ref_count_out = REF_OUT_W'(tbl_refs[p]);
                    end
                end
            end
            default:
            begin
                res.status = STAT_BAD;
            end
        endcase
        return res;
    endfunction

    function automatic in_item_t make_item(input logic [OP_W-1:0] op,
                                           input logic [WORD_W-1:0] idx,
                                           input logic [WORD_W-1:0] chk,
                                           input logic [CHECK_W-1:0] nchk);
        in_item_t it;
        it.op           = op;
        it.handle_index = idx;
        it.handle_check = chk;
        it.new_check    = nchk;
        return it;
    endfunction

    // Sends one item, waits for its transfer and records the result it should give.
    task automatic send_op(input in_item_t it);
        int gap;
        gap = (idle_on && $urandom_range(99) < 22) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_expected = table_apply(it);
        expected_results.push_back(last_expected);
        items_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Receiver stalls at random while idling is enabled.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !(idle_on && $urandom_range(99) < 22);
    end

    // Each result transfer is compared with the oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no outstanding item: 0x%0h", out_item);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, out_item.status);
                check_field("slot_out", want.slot_out, out_item.slot_out);
                check_field("check_out", want.check_out, out_item.check_out);
                check_field("ref_count_out", want.ref_count_out, out_item.ref_count_out);
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // Random active slot below the used count, or -1 when there is none.
    function automatic int pick_active();
        int start;
        int s;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            s = (start + k) % SLOTS;
            if (s < tbl_used && tbl_state[s] == SS_ACTIVE)
                return s;
        end
        return -1;
    endfunction

    function automatic logic [WORD_W-1:0] pick_index();
        int r;
        int s;
        r = $urandom_range(99);
        s = pick_active();
        if (r < 85 && s >= 0)
            return WORD_W'(s);
        if (r < 95 && tbl_used > 0)
            return WORD_W'($urandom_range(tbl_used - 1));
        if (r < 98)
            return WORD_W'(tbl_used) + WORD_W'($urandom_range(3));
        return $urandom();
    endfunction

    function automatic logic [WORD_W-1:0] pick_check(input logic [WORD_W-1:0] idx);
        int                r;
        logic [WORD_W-1:0] stored;
        logic [WORD_W-1:0] wrong;
        r      = $urandom_range(99);
        stored = {1'b0, tbl_check[idx[SLOT_W-1:0]]};
        if (r < 25)
            return WILDCARD;
        if (r < 90)
            return stored;
        // A flipped bit, never turning the word into the wildcard
        wrong = stored ^ (32'h1 << $urandom_range(31));
        if (wrong == WILDCARD)
            wrong = stored ^ 32'h1;
        return wrong;
    endfunction

    function automatic in_item_t random_item(input int mix);
        in_item_t it;
        int       r;
        int       wc;
        int       wg;
        int       wp;
        int       wd;
        case (mix)
            MIX_GROW:   begin wc = 35; wg = 15; wp = 10; wd = 5;  end
            MIX_SHRINK: begin wc = 8;  wg = 12; wp = 30; wd = 20; end
            default:    begin wc = 20; wg = 18; wp = 17; wd = 10; end
        endcase
        r            = $urandom_range(99);
        it.new_check = CHECK_W'($urandom());
        if (r < wc + wg + wp + wd + 24)
        begin
            if (r < wc)
                it.op = OP_CREATE;
            else if (r < wc + wg)
                it.op = OP_GET;
            else if (r < wc + wg + wp)
                it.op = OP_PUT;
            else if (r < wc + wg + wp + wd)
                it.op = OP_DESTROY;
            else if (r < wc + wg + wp + wd + 10)
                it.op = OP_QUERY;
            else if (r < wc + wg + wp + wd + 13)
                it.op = OP_ITER_RESET;
            else
                it.op = OP_ITER_NEXT;
            it.handle_index = pick_index();
            it.handle_check = pick_check(it.handle_index);
        end
        else
        begin
            // Noise: any opcode, any handle
            it.op           = OP_W'($urandom_range(7));
            it.handle_index = $urandom();
            it.handle_check = $urandom();
        end
        return it;
    endfunction

    task automatic test_empty_table();
        send_op(make_item(OP_ITER_NEXT, 0, 0, 0));
        send_op(make_item(OP_GET, 0, WILDCARD, 0));
        send_op(make_item(OP_QUERY, 32'hFFFF_FFFF, WILDCARD, 0));
        send_op(make_item(OP_UNUSED, $urandom(), $urandom(), CHECK_W'($urandom())));
        send_op(make_item(OP_ITER_RESET, 0, 0, 0));
    endtask

    task automatic test_create_get_put();
        send_op(make_item(OP_CREATE, 0, 0, 31'h0));
        send_op(make_item(OP_CREATE, 0, 0, 31'h7FFF_FFFF));
        send_op(make_item(OP_GET, 1, 32'h7FFF_FFFF, 0));
        send_op(make_item(OP_GET, 1, WILDCARD, 0));
        // A check word with bit 31 set, other than the wildcard, never matches a stored check.
        send_op(make_item(OP_GET, 0, 32'h8000_0000, 0));
        send_op(make_item(OP_GET, 0, 32'h1, 0));
        send_op(make_item(OP_QUERY, 1, WILDCARD, 0));
        send_op(make_item(OP_PUT, 0, 32'h0, 0));
        send_op(make_item(OP_GET, 0, WILDCARD, 0));
        send_op(make_item(OP_CREATE, 0, 0, CHECK_W'($urandom())));
    endtask

    task automatic test_destroy_pending();
        send_op(make_item(OP_DESTROY, 1, 32'h7FFF_FFFF, 0));
        send_op(make_item(OP_GET, 1, WILDCARD, 0));
        send_op(make_item(OP_QUERY, 1, WILDCARD, 0));
        // The iterator finds slot 0, skips the pending slot and then runs out.
        send_op(make_item(OP_ITER_RESET, 0, 0, 0));
        send_op(make_item(OP_ITER_NEXT, 0, 0, 0));
        send_op(make_item(OP_ITER_NEXT, 0, 0, 0));
        send_op(make_item(OP_ITER_NEXT, 0, 0, 0));
        send_op(make_item(OP_PUT, 1, WILDCARD, 0));
        send_op(make_item(OP_PUT, 1, WILDCARD, 0));
    endtask

    // A put on a cleared slot wraps its count without touching the state.
    task automatic test_put_wrap();
        send_op(make_item(OP_PUT, 1, 32'h0, 0));
        send_op(make_item(OP_QUERY, 1, 32'h0, 0));
        send_op(make_item(OP_CREATE, 0, 0, CHECK_W'($urandom())));
    endtask

    // Takes a burst of references on a fresh slot, back to back with no stalls.
    task automatic test_get_burst();
        logic [WORD_W-1:0] slot;
        idle_on = 1'b0;
        send_op(make_item(OP_CREATE, 0, 0, CHECK_W'($urandom())));
        slot = WORD_W'(last_expected.slot_out);
        repeat (GET_BURST)
            send_op(make_item(OP_GET, slot, WILDCARD, 0));
        send_op(make_item(OP_QUERY, slot, WILDCARD, 0));
        send_op(make_item(OP_PUT, slot, WILDCARD, 0));
        idle_on = 1'b1;
    endtask

    task automatic test_table_full();
        bit room;
        room = 1'b1;
        while (room)
        begin
            room = (tbl_used < SLOTS);
            for (int i = 0; i < tbl_used; i++)
            begin
                if (tbl_state[i] == SS_EMPTY)
                    room = 1'b1;
            end
            if (room)
                send_op(make_item(OP_CREATE, 0, 0, CHECK_W'($urandom())));
        end
        send_op(make_item(OP_CREATE, 0, 0, CHECK_W'($urandom())));
    endtask

    // Phases start by draining the full table, then step through the balanced, grow and steady mixes.
    task automatic test_random();
        int mix;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mix     = (n / 130) % 4;
            idle_on = (mix != MIX_STEADY);
            send_op(random_item(mix));
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        int waited;
        table_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_table();
        test_create_get_put();
        test_destroy_pending();
        test_put_wrap();
        test_get_burst();
        test_table_full();
        test_random();

        // Let the last results drain, with a bound.
        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end

        $display("Covered %0d items in and %0d results out, with %0d errors.",
                 items_sent, results_checked, errors);
        $display("Statuses seen: ok %0d, bad handle %0d, table full %0d, iterator end %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
